// ===== hw/rtl/mtfs_pkg.sv =====
// Package for the message-to-frame segmenter: byte type and frame constants.
// Has no dependencies. The interfaces and the top level use it; the RAM does not.
package mtfs_pkg;

    typedef logic [7:0] byte_t;

    // Flag byte values, ASCII '1' and '0'.
    localparam byte_t FLAG_LAST    = 8'h31;
    localparam byte_t FLAG_MORE    = 8'h30;
    // The length byte is this value plus the payload count.
    localparam byte_t HEADER_EXTRA = 8'd3;

endpackage

// ===== hw/rtl/mtfs_if.sv =====
// Valid/ready channel interfaces for the segmenter's message input and frame output.
// Depends on mtfs_pkg for the byte type.
interface mtfs_in_if;
    import mtfs_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface mtfs_out_if;
    import mtfs_pkg::*;

    logic  valid;
    logic  ready;
    byte_t frame_byte;
    logic  frame_last_byte;

    modport source (output valid, output frame_byte, output frame_last_byte, input ready);
    modport sink   (input valid, input frame_byte, input frame_last_byte, output ready);
endinterface

// ===== hw/rtl/message_to_frame_segmenter.sv =====
// A byte that does not close a frame is accepted while collecting; the closing byte's
// transfer moves the sequencer to its emit state, which loads the frame's first byte into
// the output register once that register is free; it can transfer out from there.
// Throughput: one input byte per cycle while collecting; a frame of PAYLOAD_BYTES+3 bytes
// then goes through the frame sequencer, one byte per cycle through the output register
// when the output does not stall, and input is held off until its flag byte is loaded.
// Reset: asynchronous, active low; clears the fill count, sequence number, sequencer and
// output valid. The payload RAM is not cleared, since unfilled positions are sent as zero.
module message_to_frame_segmenter #(
    parameter int PAYLOAD_BYTES = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    mtfs_in_if.sink         msg_in,
    mtfs_out_if.source      frame_out
);
    import mtfs_pkg::*;

    // Widths follow from the payload size. The frame index runs over header, payload and
    // flag; the fill count must be able to hold PAYLOAD_BYTES itself.
    localparam int AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W = $clog2(PAYLOAD_BYTES + 3);
    localparam int CMP_W = IDX_W + 1;

    localparam logic [IDX_W-1:0] IDX_SEQ  = '0;
    localparam logic [IDX_W-1:0] IDX_LEN  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_FLAG = IDX_W'(PAYLOAD_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_BYTES);

    // Sequencer states.
    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    byte_t            seq_reg, seq_next;
    logic             ending_reg, ending_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    byte_t            out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic             in_xfer;
    logic             load;
    logic [CNT_W-1:0] fill_inc;
    logic             frame_done;
    logic [IDX_W-1:0] pay_idx;
    logic [AW-1:0]    rd_addr;
    byte_t            rd_data;
    logic             pay_valid;
    byte_t            cur_byte;

    // The buffer takes bytes only while collecting; the output register is a separate
    // stage, so a frame's last byte may still wait there while new bytes arrive.
    assign msg_in.ready = (state_reg == ST_COLLECT);
    assign in_xfer      = msg_in.valid && msg_in.ready;
    assign fill_inc     = fill_reg + CNT_W'(1);

    // The sequencer hands a byte to the output register whenever that register is empty
    // or is being emptied in this cycle.
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || frame_out.ready);
    assign frame_done = load && (idx_reg == IDX_FLAG);

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = frame_done ? IDX_SEQ : idx_reg + IDX_W'(1);
        end
    end

    // The RAM read is registered. The address is taken from the next index,
    // so the read data always belongs to the index held in idx_reg. Writes happen only
    // while collecting, so no payload read during emission overlaps a write.
    assign pay_idx = idx_next - IDX_W'(2);
    assign rd_addr = pay_idx[AW-1:0];

    mtfs_ram #(
        .WIDTH ($bits(byte_t)),
        .DEPTH (PAYLOAD_BYTES)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (in_xfer),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (msg_in.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Payload positions at or beyond the fill count go out as zero padding.
    assign pay_valid = ({1'b0, idx_reg} < (CMP_W'(fill_reg) + CMP_W'(2)));

    always_comb
    begin
        if (idx_reg == IDX_SEQ)
        begin
            cur_byte = seq_reg;
        end
        else if (idx_reg == IDX_LEN)
        begin
            cur_byte = HEADER_EXTRA + 8'(fill_reg);
        end
        else if (idx_reg == IDX_FLAG)
        begin
            cur_byte = ending_reg ? FLAG_LAST : FLAG_MORE;
        end
        else
        begin
            cur_byte = pay_valid ? rd_data : '0;
        end
    end

    // Collection and frame bookkeeping.
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        seq_next    = seq_reg;
        ending_next = ending_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    fill_next = fill_inc;
                    if (msg_in.message_end || (fill_inc == CNT_FULL))
                    begin
                        ending_next = msg_in.message_end;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (frame_done)
                begin
                    fill_next  = '0;
                    state_next = ST_COLLECT;
                    // The sequence number restarts after a message's last frame.
                    seq_next   = ending_reg ? 8'd0 : seq_reg + 8'd1;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = (idx_reg == IDX_FLAG);
        end
        else if (frame_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            fill_reg      <= '0;
            seq_reg       <= '0;
            ending_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            ending_reg    <= ending_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign frame_out.valid           = out_valid_reg;
    assign frame_out.frame_byte      = out_byte_reg;
    assign frame_out.frame_last_byte = out_last_reg;

endmodule

// ===== hw/rtl/mtfs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone, with no package dependency.
module mtfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
